// ===== rtl/core/lta_pkg.sv =====
package lta_pkg;

  // Stream payload widths
  localparam int LenW     = 8;
  localparam int SymW     = 10;
  localparam int AirW     = 32;
  localparam int TmoW     = 24;
  localparam int InDataW  = 8;
  localparam int OutDataW = 72;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 19;

  // Register widths
  localparam int SfW  = 4;
  localparam int BwW  = 19;
  localparam int CrW  = 4;
  localparam int PreW = 16;

  // Internal widths
  localparam int KW     = 4;   // bits per chirp after low-rate reduction, 3..12
  localparam int NumW   = 12;  // payload numerator
  localparam int AqW    = 10;  // block divider dividend / quotient
  localparam int SymExW = 11;  // exact symbol count
  localparam int QW     = 19;  // quarter symbols
  localparam int XW     = 26;  // quarter symbols times 125
  localparam int DivW   = 45;  // airtime dividend
  localparam int ShW    = 5;   // dividend shift, SF + 7

  localparam int SymCells = AqW;
  localparam int DivCells = DivW;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSf       = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBw       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCr       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLowRate  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegExplicit = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCrc      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPreamble = 3'd6;

  // Register limits and reset values
  localparam logic [SfW-1:0]  SfMin      = 4'd5;
  localparam logic [SfW-1:0]  SfMax      = 4'd12;
  localparam logic [SfW-1:0]  SfReset    = 4'd7;
  localparam logic [CrW-1:0]  CrMin      = 4'd5;
  localparam logic [CrW-1:0]  CrMax      = 4'd8;
  localparam logic [CrW-1:0]  CrReset    = 4'd5;
  localparam logic [BwW-1:0]  BwDefault  = 19'd125000;
  localparam logic [PreW-1:0] PreReset   = 16'd16;

  localparam logic [SymW-1:0]   SymFieldMax = '1;
  localparam logic [SymExW-1:0] HeaderSyms  = 11'd8;
  localparam logic [QW-1:0]     PreambleExtra = 19'd17;  // 4.25 symbols in quarters
  localparam logic [AirW-1:0]   AirMax = '1;
  localparam logic [TmoW-1:0]   TmoMax = '1;

  typedef struct packed {
    logic           valid;
    logic           zero;    // numerator not positive, eight symbols only
    logic [KW-1:0]  rem;
    logic [AqW-1:0] aq;      // dividend bits shift out, quotient bits shift in
  } sym_cell_t;

  typedef struct packed {
    logic            valid;
    logic [SymW-1:0] sym_field;
    logic [BwW-1:0]  rem;
    logic [DivW-1:0] dq;
  } div_cell_t;

endpackage

// ===== rtl/core/lta_sym_cell.sv =====
module lta_sym_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [lta_pkg::KW-1:0]    k,
  input  lta_pkg::sym_cell_t        d_i,
  output lta_pkg::sym_cell_t        d_o
);

  logic [lta_pkg::KW:0]   trial;
  logic [lta_pkg::KW:0]   diff;
  logic                   take;
  lta_pkg::sym_cell_t     d_nxt;
  lta_pkg::sym_cell_t     d_r;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {d_i.rem, d_i.aq[lta_pkg::AqW-1]};
    diff  = trial - {1'b0, k};
    take  = trial >= {1'b0, k};
    d_nxt = d_i;
    d_nxt.rem = take ? diff[lta_pkg::KW-1:0] : trial[lta_pkg::KW-1:0];
    d_nxt.aq  = {d_i.aq[lta_pkg::AqW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// ===== rtl/core/lta_div_cell.sv =====
module lta_div_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [lta_pkg::BwW-1:0]   bw,
  input  lta_pkg::div_cell_t        d_i,
  output lta_pkg::div_cell_t        d_o
);

  logic [lta_pkg::BwW:0]  trial;
  logic [lta_pkg::BwW:0]  diff;
  logic                   take;
  lta_pkg::div_cell_t     d_nxt;
  lta_pkg::div_cell_t     d_r;

  always_comb begin
    trial = {d_i.rem, d_i.dq[lta_pkg::DivW-1]};
    diff  = trial - {1'b0, bw};
    take  = trial >= {1'b0, bw};
    d_nxt = d_i;
    d_nxt.rem = take ? diff[lta_pkg::BwW-1:0] : trial[lta_pkg::BwW-1:0];
    d_nxt.dq  = {d_i.dq[lta_pkg::DivW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r <= '0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// ===== rtl/core/lora_time_on_air.sv =====
// LoRa time-on-air calculator.
// in_*  : one item per payload length (in_tdata[7:0] = payload_length, bytes).
// out_* : one result item per input item, in order.
// cfg_* : register writes, index 0..6 = SF, bandwidth, coding rate, low-rate
//         optimize, explicit header, CRC, preamble length; other indexes are
//         dropped. cfg_ready is always high. Write only while no item is in flight.
// The block is a row of one-bit division cells: ten cells divide the payload
// numerator by the bits per chirp, forty-five more divide the scaled quarter
// symbol count by the bandwidth. Each cell passes its partial remainder and
// quotient to the next every cycle while the row advances, so a new length is
// accepted every clock unless the row is stalled. While out_tvalid waits on
// out_tready the row keeps moving until a result reaches its last cell, then
// in_tready drops until the output register is freed. Reset (rst_n low,
// synchronous) empties the row and the output register and loads SF 7,
// 125 kHz, CR 4/5, low-rate off, explicit header, CRC on and a 16 symbol
// preamble.
module lora_time_on_air (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lta_pkg::InDataW-1:0]    in_tdata,   // [7:0] payload_length

  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [9:0] payload_symbols, [41:10] airtime_ticks, [65:42] timeout_ticks, rest zero
  output logic [lta_pkg::OutDataW-1:0]   out_tdata,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lta_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [lta_pkg::CfgDataW-1:0]   cfg_data
);

  // Configuration, stored already clamped
  logic [lta_pkg::SfW-1:0]  sf_r;
  logic [lta_pkg::BwW-1:0]  bw_r;
  logic [lta_pkg::CrW-1:0]  cr_r;
  logic                     low_rate_r;
  logic                     explicit_r;
  logic                     crc_r;
  logic [lta_pkg::PreW-1:0] pre_r;

  logic [lta_pkg::SfW-1:0]  sf_wr;
  logic [lta_pkg::CrW-1:0]  cr_wr;
  logic [lta_pkg::BwW-1:0]  bw_wr;

  logic                     adv;
  logic [lta_pkg::KW-1:0]   k;

  // Front end
  logic [lta_pkg::NumW-1:0] pos;
  logic [lta_pkg::NumW-1:0] neg;
  logic [lta_pkg::NumW-1:0] num;
  logic [lta_pkg::NumW-1:0] num_ceil;
  logic [lta_pkg::AqW-1:0]  a_div;
  lta_pkg::sym_cell_t       sym_a_nxt;

  lta_pkg::sym_cell_t       sym_chain [lta_pkg::SymCells+1];
  lta_pkg::div_cell_t       div_chain [lta_pkg::DivCells+1];

  // Symbol stage
  logic [lta_pkg::AqW+lta_pkg::CrW-1:0] blk_prod;
  logic [lta_pkg::AqW+lta_pkg::CrW-1:0] sym_sum;
  logic [lta_pkg::SymExW-1:0]           sym_b_nxt;
  logic [lta_pkg::SymExW-1:0]           sym_b_r;
  logic                                 valid_b_r;

  // Quarter symbol stage
  logic [lta_pkg::QW-1:0]   q_sum;
  logic [lta_pkg::XW-1:0]   x_nxt;
  logic [lta_pkg::XW-1:0]   x_c_r;
  logic [lta_pkg::SymW-1:0] symf_c_r;
  logic                     valid_c_r;

  // Dividend alignment
  logic [lta_pkg::ShW-1:0]  shamt;
  lta_pkg::div_cell_t       div_d_nxt;

  // Output
  logic [lta_pkg::DivW-1:0]  quo;
  logic [lta_pkg::BwW+1:0]   rem3;
  logic [1:0]                frac3;
  logic [lta_pkg::TmoW+1:0]  tmo_sum;
  logic [lta_pkg::AirW-1:0]  air_nxt;
  logic [lta_pkg::TmoW-1:0]  tmo_nxt;

  logic                      out_valid_r;
  logic [lta_pkg::SymW-1:0]  out_sym_r;
  logic [lta_pkg::AirW-1:0]  out_air_r;
  logic [lta_pkg::TmoW-1:0]  out_tmo_r;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    sf_wr = cfg_data[lta_pkg::SfW-1:0];
    if (sf_wr < lta_pkg::SfMin) begin
      sf_wr = lta_pkg::SfMin;
    end else if (sf_wr > lta_pkg::SfMax) begin
      sf_wr = lta_pkg::SfMax;
    end
    cr_wr = cfg_data[lta_pkg::CrW-1:0];
    if (cr_wr < lta_pkg::CrMin) begin
      cr_wr = lta_pkg::CrMin;
    end else if (cr_wr > lta_pkg::CrMax) begin
      cr_wr = lta_pkg::CrMax;
    end
    bw_wr = (cfg_data[lta_pkg::BwW-1:0] == '0) ? lta_pkg::BwDefault
                                                : cfg_data[lta_pkg::BwW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sf_r       <= lta_pkg::SfReset;
      bw_r       <= lta_pkg::BwDefault;
      cr_r       <= lta_pkg::CrReset;
      low_rate_r <= 1'b0;
      explicit_r <= 1'b1;
      crc_r      <= 1'b1;
      pre_r      <= lta_pkg::PreReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lta_pkg::RegSf:       sf_r       <= sf_wr;
        lta_pkg::RegBw:       bw_r       <= bw_wr;
        lta_pkg::RegCr:       cr_r       <= cr_wr;
        lta_pkg::RegLowRate:  low_rate_r <= cfg_data[0];
        lta_pkg::RegExplicit: explicit_r <= cfg_data[0];
        lta_pkg::RegCrc:      crc_r      <= cfg_data[0];
        lta_pkg::RegPreamble: pre_r      <= cfg_data[lta_pkg::PreW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the row moves unless a finished result would run into a
  // held output register.
  // ---------------------------------------------------------------------------
  assign adv       = !out_valid_r || out_tready || !div_chain[lta_pkg::DivCells].valid;
  assign in_tready = adv;

  assign k = sf_r - {2'b00, low_rate_r, 1'b0};

  // ---------------------------------------------------------------------------
  // Front end: numerator and ceiling offset
  // ---------------------------------------------------------------------------
  always_comb begin
    pos = {1'b0, in_tdata[lta_pkg::LenW-1:0], 3'b000} + 12'd28 + {7'd0, crc_r, 4'b0000};
    neg = {6'd0, sf_r, 2'b00} + (explicit_r ? 12'd0 : 12'd20);
    num = pos - neg;
    num_ceil = (num + 12'd3) >> 2;
    // ceil(num / (4k)) = floor((ceil(num/4) + k - 1) / k)
    a_div = num_ceil[lta_pkg::AqW-1:0] + {6'd0, k} - 10'd1;

    sym_a_nxt.valid = in_tvalid;
    sym_a_nxt.zero  = pos <= neg;
    sym_a_nxt.rem   = '0;
    sym_a_nxt.aq    = a_div;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_chain[0] <= '0;
    end else if (adv) begin
      sym_chain[0] <= sym_a_nxt;
    end
  end

  for (genvar i = 0; i < lta_pkg::SymCells; i++) begin : g_sym
    lta_sym_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .k     (k),
      .d_i   (sym_chain[i]),
      .d_o   (sym_chain[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Symbol count
  // ---------------------------------------------------------------------------
  always_comb begin
    blk_prod  = {{lta_pkg::CrW{1'b0}}, sym_chain[lta_pkg::SymCells].aq}
              * {{lta_pkg::AqW{1'b0}}, cr_r};
    sym_sum   = blk_prod + {3'd0, lta_pkg::HeaderSyms};
    sym_b_nxt = sym_chain[lta_pkg::SymCells].zero ? lta_pkg::HeaderSyms
                                                  : sym_sum[lta_pkg::SymExW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (adv) begin
      valid_b_r <= sym_chain[lta_pkg::SymCells].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sym_b_r <= sym_b_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Quarter symbols times 125 (16000 = 125 * 2^7)
  // ---------------------------------------------------------------------------
  always_comb begin
    q_sum = {1'b0, pre_r, 2'b00} + lta_pkg::PreambleExtra + {6'd0, sym_b_r, 2'b00};
    x_nxt = {{(lta_pkg::XW-lta_pkg::QW){1'b0}}, q_sum} * 26'd125;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_c_r <= 1'b0;
    end else if (adv) begin
      valid_c_r <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_c_r    <= x_nxt;
      symf_c_r <= (sym_b_r > {1'b0, lta_pkg::SymFieldMax}) ? lta_pkg::SymFieldMax
                                                          : sym_b_r[lta_pkg::SymW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Dividend alignment and bandwidth division
  // ---------------------------------------------------------------------------
  always_comb begin
    shamt               = {1'b0, sf_r} + 5'd7;
    div_d_nxt.valid     = valid_c_r;
    div_d_nxt.sym_field = symf_c_r;
    div_d_nxt.rem       = '0;
    div_d_nxt.dq        = {{(lta_pkg::DivW-lta_pkg::XW){1'b0}}, x_c_r} << shamt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_chain[0] <= '0;
    end else if (adv) begin
      div_chain[0] <= div_d_nxt;
    end
  end

  for (genvar i = 0; i < lta_pkg::DivCells; i++) begin : g_div
    lta_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .bw    (bw_r),
      .d_i   (div_chain[i]),
      .d_o   (div_chain[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Saturation and timeout: 3*D/bw = 3q + floor(3r/bw), the last term 0..2
  // ---------------------------------------------------------------------------
  always_comb begin
    quo   = div_chain[lta_pkg::DivCells].dq;
    rem3  = {2'b00, div_chain[lta_pkg::DivCells].rem}
          + {1'b0, div_chain[lta_pkg::DivCells].rem, 1'b0};
    if (rem3 >= {1'b0, bw_r, 1'b0}) begin
      frac3 = 2'd2;
    end else if (rem3 >= {2'b00, bw_r}) begin
      frac3 = 2'd1;
    end else begin
      frac3 = 2'd0;
    end
    tmo_sum = {2'b00, quo[lta_pkg::TmoW-1:0]} + {1'b0, quo[lta_pkg::TmoW-1:0], 1'b0}
            + {24'd0, frac3};
    air_nxt = (quo[lta_pkg::DivW-1:lta_pkg::AirW] != '0) ? lta_pkg::AirMax
                                                         : quo[lta_pkg::AirW-1:0];
    tmo_nxt = ((quo[lta_pkg::DivW-1:lta_pkg::TmoW] != '0) ||
               (tmo_sum[lta_pkg::TmoW+1:lta_pkg::TmoW] != 2'b00)) ?
              lta_pkg::TmoMax : tmo_sum[lta_pkg::TmoW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= div_chain[lta_pkg::DivCells].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_sym_r <= div_chain[lta_pkg::DivCells].sym_field;
      out_air_r <= air_nxt;
      out_tmo_r <= tmo_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_tmo_r, out_air_r, out_sym_r};

`ifndef SYNTHESIS
  // A result in the last cell never moves while the output register is held.
  assert property (@(posedge clk) disable iff (!rst_n)
    (div_chain[lta_pkg::DivCells].valid && out_valid_r && !out_tready) |-> !adv)
    else $error("row advanced over a held result");

  // Division remainders stay below their divisors.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_chain[lta_pkg::DivCells].valid |-> (div_chain[lta_pkg::DivCells].rem < bw_r))
    else $error("bandwidth remainder out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    sym_chain[lta_pkg::SymCells].valid |-> (sym_chain[lta_pkg::SymCells].rem < k))
    else $error("block remainder out of range");

  // Unclamped timeout is at least three times the airtime.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_tmo_r != lta_pkg::TmoMax)) |->
      ({10'd0, out_tmo_r} >= {out_air_r, 2'b00} - {2'b00, out_air_r}))
    else $error("timeout below three times airtime");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sym_r >= 10'd8))
    else $error("fewer than eight symbols");
`endif

endmodule
